/* src/assert_macros.svh */
// assertion macros used by the allocator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* src/fpba_pkg.sv */
// shared constants and codes for the fit-policy block allocator
package fpba_pkg;

	// parameter defaults
	localparam int NUM_BLOCKS_DEF = 8;
	localparam int SIZE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int INDEX_W  = 3;
	localparam int AMOUNT_W = 16;
	localparam int LEFT_W   = 16;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	// placement policy codes
	localparam logic POLICY_FIRST = 1'b0;
	localparam logic POLICY_BEST  = 1'b1;

endpackage

/* src/fpba_ram.sv */
// generic single-write, single-read ram with registered read data
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/fit_policy_block_allocator_top.sv */
// fit-policy block allocator: free-space table with first-fit / best-fit allocation
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_data (policy)   | in
//  in      | in_valid, in_ready, action, block_index,  | in
//          | amount                                   |
//  out     | out_valid, out_ready, granted,            | out
//          | chosen_block, space_left                 |
//
//  a load beat passes through the load state, an allocate beat through the scan,
//  tail and finish states, reading one table entry per cycle from the ram port.
//  in_ready is high only while the sequencer is idle; a finished result waits
//  in the output register while the next beat is accepted.
//  reset clears the table through per-block valid bits, policy resets to first fit.
//  the cfg channel is always ready.
module fit_policy_block_allocator_top
	#(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	// input beats
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [fpba_pkg::INDEX_W-1:0]   block_index,
	input  logic [fpba_pkg::AMOUNT_W-1:0]  amount,
	// result beats
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           granted,
	output logic [fpba_pkg::INDEX_W-1:0]   chosen_block,
	output logic [fpba_pkg::LEFT_W-1:0]    space_left
);

	import fpba_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int WIDE_W = IDX_W + INDEX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	state_t state_q;

	// latched beat
	logic                  act_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [SIZE_WIDTH-1:0] amt_q;
	logic                  policy_q;

	// scan state
	logic [IDX_W-1:0]      cnt_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_WIDTH-1:0] best_q;

	// table valid bits
	logic [NUM_BLOCKS-1:0] valid_q;

	// output register
	logic                  out_valid_q;
	logic                  granted_q;
	logic [INDEX_W-1:0]    chosen_q;
	logic [LEFT_W-1:0]     left_q;

	// ram ports
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [SIZE_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [SIZE_WIDTH-1:0] ram_rdata;

	// derived combinational values
	logic                  slot_free;
	logic                  post_result;
	logic                  in_fire;
	logic                  load_ok;
	logic [WIDE_W-1:0]     idx_wide;
	logic [WIDE_W-1:0]     pick_wide;
	logic [SIZE_WIDTH-1:0] cur_space;
	logic                  fits;
	logic                  take;
	logic [SIZE_WIDTH-1:0] remain;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// a result is posted from the load or finish state once the slot is free
	assign post_result = slot_free && ((state_q == ST_LOAD) || (state_q == ST_FINISH));

	// index width conversions
	assign idx_wide  = WIDE_W'(idx_q);
	assign pick_wide = WIDE_W'(pick_q);
	assign load_ok   = (int'(idx_q) < NUM_BLOCKS);

	// compare unit on the entry read back from the ram
	assign cur_space = valid_q[rd_idx_s1] ? ram_rdata : '0;
	assign fits      = (amt_q <= cur_space);
	assign take      = rd_vld_s1 && fits &&
		(!found_q || ((policy_q == POLICY_BEST) && (cur_space < best_q)));
	assign remain    = best_q - amt_q;

	// ram read during the scan
	assign ram_re    = (state_q == ST_SCAN);
	assign ram_raddr = cnt_q;

	// ram write for load and for the allocation write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_wide[IDX_W-1:0];
		ram_wdata = amt_q;
		case (state_q)
			ST_LOAD: begin
				ram_we = slot_free && load_ok;
			end
			ST_FINISH: begin
				ram_we    = slot_free && found_q;
				ram_waddr = pick_q;
				ram_wdata = remain;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	fpba_ram #(
		.WIDTH(SIZE_WIDTH),
		.DEPTH(NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer, scan registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_LOAD;
			idx_q       <= '0;
			amt_q       <= '0;
			policy_q    <= POLICY_FIRST;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			granted_q   <= 1'b0;
			chosen_q    <= '0;
			left_q      <= '0;
		end else begin
			// policy register write
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end

			// result beat posted or taken
			if (post_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// table entry becomes valid once written
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			// compare stage
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= rd_idx_s1;
				best_q  <= cur_space;
			end

			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_fire) begin
						act_q   <= action;
						idx_q   <= block_index;
						amt_q   <= SIZE_WIDTH'(amount);
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= (action == ACT_ALLOC) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (slot_free) begin
						granted_q   <= 1'b0;
						chosen_q    <= idx_q;
						left_q      <= load_ok ? LEFT_W'(amt_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= cnt_q;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_TAIL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TAIL: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free) begin
						granted_q   <= found_q;
						chosen_q    <= found_q ? pick_wide[INDEX_W-1:0] : '0;
						left_q      <= found_q ? LEFT_W'(remain) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign space_left   = left_q;

	// checks
	`ASSERT_SAME(a_cmp_in_scan, clk, arst_n, rd_vld_s1, (state_q == ST_SCAN) || (state_q == ST_TAIL))
	`ASSERT_NEXT(a_write_posts_result, clk, arst_n, ram_we, out_valid_q)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_fire, !in_ready)
	`ASSERT_SAME(a_load_not_granted, clk, arst_n, (state_q == ST_LOAD) && (act_q == ACT_ALLOC), 1'b0)

endmodule
